// ===== rtl/hce_pkg.sv =====
// Shared types and constants for the Hilbert curve index encoder.
package hce_pkg;

    localparam int COORD_W  = 16;
    localparam int DIST_W   = 32;
    localparam int SAMPLE_W = 32;
    localparam int ORDER_W  = 5;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(5);

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [DIST_W-1:0]   curve_idx;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

endpackage

// ===== rtl/hce_cell.sv =====
// One curve level: quadrant bits, distance digit, reflect and swap, registered.
module hce_cell #(
    parameter int LEVEL = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [hce_pkg::ORDER_W-1:0]   i_order,
    input  logic                          i_vld,
    input  hce_pkg::t_item                i_item,
    output logic                          o_vld,
    output hce_pkg::t_item                o_item
);
    import hce_pkg::*;

    localparam logic [COORD_W-1:0] LOW_MASK = COORD_W'((1 << LEVEL) - 1);

    logic   r_vld;
    t_item  r_item;
    t_item  n_item;
    logic   active;
    logic   rx;
    logic   ry;
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;

    assign active = ORDER_W'(LEVEL) < i_order;
    assign rx     = i_item.x[LEVEL];
    assign ry     = i_item.y[LEVEL];

    always_comb begin
        n_item = i_item;
        xa     = i_item.x;
        ya     = i_item.y;
        if (active) begin
            n_item.curve_idx[2*LEVEL +: 2] = {rx, rx ^ ry};
            if (!ry) begin
                if (rx) begin
                    xa = ~i_item.x;
                    ya = ~i_item.y;
                end
                n_item.x = ya & LOW_MASK;
                n_item.y = xa & LOW_MASK;
            end else begin
                n_item.x = i_item.x & LOW_MASK;
                n_item.y = i_item.y & LOW_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/hilbert_curve_index_encoder.sv =====
// Top level of the Hilbert curve index encoder.
// Takes one pixel per clock unless stalled and gives its Hilbert curve distance within
// a square of side 2^curve_order, with the sample alongside. The chain is an input
// register that crops pixels outside the square, then one cell per curve level,
// top bit first; the last cell is the output register. Cropped pixels produce no
// transfer. The whole chain advances together and stalls while a result waits.
// curve_order above MAX_ORDER acts as MAX_ORDER; write it only while the chain is empty.
module hilbert_curve_index_encoder #(
    parameter int MAX_ORDER = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,       // curve_order
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [15:0] pixel_col, [31:16] pixel_row,
                                          // [63:32] sample_bits
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [31:0] curve_distance, [63:32] sample_out
);
    import hce_pkg::*;

    localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);

    logic [ORDER_W-1:0] r_curve_order;
    logic [ORDER_W-1:0] order;
    logic               en;
    logic               in_square;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               r_vld;
    t_item              r_item;
    logic               vld [MAX_ORDER+1];
    t_item              item [MAX_ORDER+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_order <= ORDER_RESET;
        end else if (i_cfg_valid) begin
            r_curve_order <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign order       = (r_curve_order > MAX_ORD) ? MAX_ORD : r_curve_order;

    assign en              = !vld[MAX_ORDER] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign col       = i_s_axis_tdata[15:0];
    assign row       = i_s_axis_tdata[31:16];
    assign in_square = ((col | row) >> order) == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_s_axis_tvalid && in_square;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item.x         <= col;
            r_item.y         <= row;
            r_item.curve_idx <= '0;
            r_item.sample    <= i_s_axis_tdata[63:32];
        end
    end

    assign vld[0]  = r_vld;
    assign item[0] = r_item;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        hce_cell #(
            .LEVEL (MAX_ORDER - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_order (order),
            .i_vld   (vld[k]),
            .i_item  (item[k]),
            .o_vld   (vld[k+1]),
            .o_item  (item[k+1])
        );
    end

    assign o_m_axis_tvalid = vld[MAX_ORDER];
    assign o_m_axis_tdata  = {item[MAX_ORDER].sample, item[MAX_ORDER].curve_idx};

endmodule

// ===== rtl/hce_checker.sv =====
// Port-level checks for the Hilbert curve index encoder, with its bind.
module hce_port_checks (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] o_m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not track output stall");

endmodule

bind hilbert_curve_index_encoder hce_port_checks u_hce_checker (.*);

// ===== sim/hce_checker.sv =====
// Checker for the Hilbert curve index encoder: watches all channels, predicts results, compares.
module hce_checker
    import hce_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    output int          o_errors,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIST_W-1:0]   curve_idx;
        logic [SAMPLE_W-1:0] sample;
    } t_curve_point;

    t_curve_point       awaited_points[$];
    logic [ORDER_W-1:0] curve_order = ORDER_RESET;

    function automatic logic [DIST_W-1:0] hilbert_distance(input int unsigned order,
            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] mask;
        logic [DIST_W-1:0]  d;
        logic               rx;
        logic               ry;
        x = col;
        y = row;
        d = '0;
        for (int lvl = int'(order) - 1; lvl >= 0; lvl--) begin
            mask = COORD_W'((32'd1 << lvl) - 32'd1);
            rx   = x[lvl];
            ry   = y[lvl];
            // quadrant weight (3*rx)^ry
            d    = d + (DIST_W'({rx, rx ^ ry}) << (2 * lvl));
            if (!ry) begin
                if (rx) begin
                    x = ~x;
                    y = ~y;
                end
                t = x;
                x = y;
                y = t;
            end
            x = x & mask;
            y = y & mask;
        end
        return d;
    endfunction

    always @(posedge i_clk) begin
        int unsigned  eff_order;
        logic [31:0]  side;
        t_curve_point exp_pt;
        t_curve_point got_pt;
        if (!i_rst_n) begin
            curve_order = ORDER_RESET;
            awaited_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                curve_order = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                eff_order = (int'(curve_order) > MAX_ORDER) ? MAX_ORDER : int'(curve_order);
                side      = 32'd1 << eff_order;
                if (32'(i_s_tdata[15:0]) < side && 32'(i_s_tdata[31:16]) < side) begin
                    exp_pt.curve_idx = hilbert_distance(eff_order, i_s_tdata[15:0],
                                                        i_s_tdata[31:16]);
                    exp_pt.sample    = i_s_tdata[63:32];
                    awaited_points.insert(awaited_points.size(), exp_pt);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got_pt.curve_idx = i_m_tdata[31:0];
                got_pt.sample    = i_m_tdata[63:32];
                if (awaited_points.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected transfer dist=%08h sample=%08h",
                                 $realtime, got_pt.curve_idx, got_pt.sample);
                end else begin
                    exp_pt = awaited_points.pop_front();
                    if (got_pt.curve_idx !== exp_pt.curve_idx ||
                        got_pt.sample !== exp_pt.sample) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"%0t: mismatch dist exp %08h got %08h, ",
                                      "sample exp %08h got %08h"},
                                     $realtime, exp_pt.curve_idx, got_pt.curve_idx,
                                     exp_pt.sample, got_pt.sample);
                    end
                end
            end
        end
        o_outstanding = awaited_points.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the Hilbert curve index encoder: clock, reset, stimulus and verdict.
module tb;
    import hce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER   = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 24;
    localparam int PHASE_ITEMS = 113;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    int          errors;
    int          outstanding;
    int          pixels_sent = 0;
    int          idle_cycles = 0;

    always #1 clk = ~clk;

    hilbert_curve_index_encoder #(
        .MAX_ORDER(MAX_ORDER)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    hce_checker #(
        .MAX_ORDER(MAX_ORDER)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned square_side(input logic [ORDER_W-1:0] order);
        return 32'd1 << ((int'(order) > MAX_ORDER) ? MAX_ORDER : int'(order));
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned side);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return COORD_W'($urandom_range(0, side - 1));
        if (r < 90)
            return ($urandom_range(0, 1) != 0) ? COORD_W'(side - 1) : '0;
        if (side > 65535)
            return COORD_W'($urandom());
        return COORD_W'($urandom_range(side, 65535));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic [SAMPLE_W-1:0] smp, input int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {smp, row, col};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // let the chain empty, including cropped pixels still in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] order);
        drain();
        cfg_data  <= order;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : sink
        int unsigned mode;
        int unsigned run_len;
        bit          held_off;
        held_off = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (!held_off && pixels_sent >= 300) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            mode    = $urandom_range(0, 9);
            run_len = $urandom_range(1, 30);
            if (mode == 9)
                run_len = $urandom_range(20, 60);
            repeat (run_len) begin
                if (mode < 4)
                    m_tready <= 1'b1;
                else if (mode < 8)
                    m_tready <= ($urandom_range(0, 3) != 0);
                else if (mode == 8)
                    m_tready <= ($urandom_range(0, 1) != 0);
                else
                    m_tready <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [ORDER_W-1:0] order_plan [10];
        logic [ORDER_W-1:0] order;
        int unsigned        side;
        bit                 burst;
        order_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd9, 5'd12, 5'd3};
        order_plan[9] = ORDER_W'($urandom_range(1, 16));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset order, square of side 32
        send_pixel(16'd0, 16'd0, 32'h0000_0000, 0);
        send_pixel(16'd31, 16'd31, 32'hFFFF_FFFF, 0);
        send_pixel(16'd31, 16'd0, 32'hA5A5_A5A5, 0);
        send_pixel(16'd0, 16'd31, 32'h5A5A_5A5A, 0);
        send_pixel(16'd16, 16'd15, 32'h1234_5678, 0);
        send_pixel(16'd32, 16'd0, 32'hDEAD_BEEF, 0);
        send_pixel(16'd0, 16'd32, 32'hCAFE_F00D, 0);
        send_pixel(16'd31, 16'd32, 32'h0000_0001, 0);
        send_pixel(16'hFFFF, 16'hFFFF, 32'h8000_0000, 0);

        write_order(5'd16);
        send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_pixel(16'h0000, 16'hFFFF, 32'h0F0F_0F0F, 0);
        send_pixel(16'hFFFF, 16'h0000, 32'hF0F0_F0F0, 0);
        send_pixel(16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 0);
        send_pixel(16'hAAAA, 16'h5555, 32'h0000_0000, 0);

        // order zero: only the origin survives
        write_order(5'd0);
        send_pixel(16'd0, 16'd0, 32'h1357_9BDF, 0);
        send_pixel(16'd1, 16'd0, 32'h2468_ACE0, 0);
        send_pixel(16'd0, 16'd1, 32'h1111_1111, 0);

        // saturates to the widest square
        write_order(5'd31);
        send_pixel(16'hFFFF, 16'hFFFF, 32'h2222_2222, 0);
        send_pixel(16'd12345, 16'd54321, 32'h3333_3333, 0);

        foreach (order_plan[p]) begin
            order = order_plan[p];
            write_order(order);
            side  = square_side(order);
            burst = (p == 0) || ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
                send_pixel(pick_coord(side), pick_coord(side), pick_sample(),
                           burst ? 0 : sender_gap());
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
